[rtl/core/encoded_polyline_decoder_unit_assert.svh]
// Assertion macros used by the checker of the polyline decoder.
// Depends on nothing; included by the checker file.
`ifndef ENCODED_POLYLINE_DECODER_UNIT_ASSERT_SVH
`define ENCODED_POLYLINE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define EPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("polyline decoder assertion failed");

// Next-cycle implication, disabled while rst is high.
`define EPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("polyline decoder assertion failed");

`endif

[rtl/core/epd_pkg.sv]
// Types and constants of the encoded polyline decoder.
// Depends on nothing; used by the result interface, the top level and the checker.
package epd_pkg;

   typedef enum logic [1:0] {
      ST_PAIR  = 2'd0,
      ST_ERROR = 2'd1,
      ST_TRUNC = 2'd2,
      ST_END   = 2'd3
   } status_type;

   localparam logic [7:0]  SYM_END   = 8'h00;
   localparam logic [7:0]  SYM_LOW   = 8'h3f;
   localparam logic [7:0]  SYM_HIGH  = 8'h7e;
   localparam int          CHUNK_W   = 5;
   localparam int          MORE_BIT  = 5;
   localparam int          COORD_W   = 32;
   localparam int          COUNT_W   = 24;
   localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

   typedef struct packed {
      status_type          status;
      logic signed [31:0]  latitude;
      logic signed [31:0]  longitude;
      logic [23:0]         point_count;
   } rsp_payload_type;

endpackage

[rtl/core/epd_req_if.sv]
// Input channel of the polyline decoder: valid, ready and one text byte.
// Depends on nothing.
interface epd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;

   modport source (output valid, output symbol, input ready);
   modport sink   (input valid, input symbol, output ready);
endinterface

[rtl/core/epd_rsp_if.sv]
// Result channel of the polyline decoder: valid, ready and one result.
// Depends on epd_pkg for the status type.
interface epd_rsp_if;
   logic                 valid;
   logic                 ready;
   epd_pkg::status_type  status;
   logic signed [31:0]   latitude;
   logic signed [31:0]   longitude;
   logic [23:0]          point_count;

   modport source (output valid, output status, output latitude, output longitude,
                   output point_count, input ready);
   modport sink   (input valid, input status, input latitude, input longitude,
                   input point_count, output ready);
endinterface

[rtl/core/encoded_polyline_decoder_unit.sv]
// Encoded polyline decoder. It takes one text byte per transaction and
// returns at most one result per byte: a coordinate pair, a parse error, or
// an end-of-polyline report. A new byte is accepted in every cycle unless
// the skid register is full. A byte's result is registered into a two-entry
// output stage (result register plus skid register), which lets the input
// keep flowing while a result waits, so ready falls only when both are full.
// Depends on epd_pkg, epd_req_if and epd_rsp_if.
module encoded_polyline_decoder_unit #(
   parameter int MAX_CHUNKS = 6
) (
   input  logic          clock,
   input  logic          reset,
   epd_req_if.sink       req_chan,
   epd_rsp_if.source     rsp_chan
);

   localparam int ACC_W = epd_pkg::CHUNK_W * MAX_CHUNKS;
   localparam int POS_W = $clog2(MAX_CHUNKS + 1);

   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic                      second_ff, second_in;
   logic                      skip_ff, skip_in;
   logic [31:0]               held_lat_ff, held_lat_in;
   logic [31:0]               run_lat_ff, run_lat_in;
   logic [31:0]               run_lon_ff, run_lon_in;
   logic [23:0]               pairs_ff, pairs_in;

   epd_pkg::rsp_payload_type  out_ff, skid_ff, res;
   logic                      out_valid_ff, skid_valid_ff;
   logic                      has_res;

   logic                      accept, out_take, in_range;
   logic [5:0]                bits;
   logic [ACC_W-1:0]          placed, acc_merged;
   logic [31:0]               mag, delta;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_take = out_valid_ff && rsp_chan.ready;
   assign req_chan.ready = !skid_valid_ff;

   assign in_range = (req_chan.symbol >= epd_pkg::SYM_LOW) &&
                     (req_chan.symbol <= epd_pkg::SYM_HIGH);
   assign bits     = 6'(req_chan.symbol - epd_pkg::SYM_LOW);

   always_comb begin
      placed = '0;
      for (int i = 0; i < MAX_CHUNKS; i++) begin
         if (pos_ff == POS_W'(i)) begin
            placed[epd_pkg::CHUNK_W*i +: epd_pkg::CHUNK_W] = bits[4:0];
         end
      end
   end

   assign acc_merged = acc_ff | placed;
   assign mag        = 32'(acc_merged[ACC_W-1:1]);
   assign delta      = acc_merged[0] ? ~mag : mag;

   always_comb begin
      acc_in      = acc_ff;
      pos_in      = pos_ff;
      second_in   = second_ff;
      skip_in     = skip_ff;
      held_lat_in = held_lat_ff;
      run_lat_in  = run_lat_ff;
      run_lon_in  = run_lon_ff;
      pairs_in    = pairs_ff;
      has_res     = 1'b0;
      res         = '{status: epd_pkg::ST_PAIR, latitude: '0, longitude: '0,
                      point_count: '0};
      if (accept) begin
         priority if (req_chan.symbol == epd_pkg::SYM_END) begin
            acc_in      = '0;
            pos_in      = '0;
            second_in   = 1'b0;
            skip_in     = 1'b0;
            held_lat_in = '0;
            run_lat_in  = '0;
            run_lon_in  = '0;
            pairs_in    = '0;
            has_res     = !skip_ff;
            res.status  = ((pos_ff != '0) || second_ff) ? epd_pkg::ST_TRUNC
                                                        : epd_pkg::ST_END;
            res.point_count = pairs_ff;
         end else if (skip_ff) begin
            has_res = 1'b0;
         end else if (!in_range || (pos_ff >= POS_W'(MAX_CHUNKS))) begin
            skip_in    = 1'b1;
            has_res    = 1'b1;
            res.status = epd_pkg::ST_ERROR;
         end else if (bits[epd_pkg::MORE_BIT]) begin
            acc_in = acc_merged;
            pos_in = pos_ff + POS_W'(1);
         end else begin
            acc_in = '0;
            pos_in = '0;
            if (!second_ff) begin
               held_lat_in = delta;
               second_in   = 1'b1;
            end else begin
               second_in   = 1'b0;
               held_lat_in = '0;
               run_lat_in  = run_lat_ff + held_lat_ff;
               run_lon_in  = run_lon_ff + delta;
               pairs_in    = (pairs_ff == epd_pkg::COUNT_MAX) ? pairs_ff
                                                              : pairs_ff + 24'd1;
               has_res         = 1'b1;
               res.status      = epd_pkg::ST_PAIR;
               res.latitude    = run_lat_in;
               res.longitude   = run_lon_in;
               res.point_count = pairs_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         pos_ff      <= '0;
         second_ff   <= 1'b0;
         skip_ff     <= 1'b0;
         held_lat_ff <= '0;
         run_lat_ff  <= '0;
         run_lon_ff  <= '0;
         pairs_ff    <= '0;
      end else begin
         acc_ff      <= acc_in;
         pos_ff      <= pos_in;
         second_ff   <= second_in;
         skip_ff     <= skip_in;
         held_lat_ff <= held_lat_in;
         run_lat_ff  <= run_lat_in;
         run_lon_ff  <= run_lon_in;
         pairs_ff    <= pairs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (has_res) begin
         if (!out_valid_ff || out_take) begin
            out_ff       <= res;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= res;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_ff.status;
   assign rsp_chan.latitude    = out_ff.latitude;
   assign rsp_chan.longitude   = out_ff.longitude;
   assign rsp_chan.point_count = out_ff.point_count;

endmodule

[rtl/core/epd_checker.sv]
// Port-level checker of the polyline decoder and its bind to the top level.
// Depends on epd_pkg and encoded_polyline_decoder_unit_assert.svh.
`include "encoded_polyline_decoder_unit_assert.svh"

module epd_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [1:0]   rsp_status,
   input logic [31:0]  rsp_latitude,
   input logic [31:0]  rsp_longitude,
   input logic [23:0]  rsp_point_count
);

   `EPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_latitude) && $stable(rsp_longitude) && $stable(rsp_point_count))
   `EPD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `EPD_ASSERT_IMPLY(a_zero_coords, clock, reset, rsp_valid && (rsp_status != epd_pkg::ST_PAIR), (rsp_latitude == 32'd0) && (rsp_longitude == 32'd0))
   `EPD_ASSERT_IMPLY(a_error_count, clock, reset, rsp_valid && (rsp_status == epd_pkg::ST_ERROR), rsp_point_count == 24'd0)

endmodule

bind encoded_polyline_decoder_unit epd_checker u_epd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_latitude    (rsp_chan.latitude),
   .rsp_longitude   (rsp_chan.longitude),
   .rsp_point_count (rsp_chan.point_count)
);
